// ===== hw/rtl/sbmt_pkg.sv =====
// ============================================================================
// Sparse block map translator package
// Shared types, command codes, result codes and constants for the translator.
// ============================================================================
`default_nettype none

package sbmt_pkg;

  // Map geometry and image constants.
  localparam logic [15:0] MAP_ENTRIES  = 16'd32760;
  localparam logic [41:0] HEADER_BYTES = 42'h8000;
  localparam logic [26:0] MIN_BLOCK    = 27'h800;
  localparam logic [26:0] MAX_BLOCK    = 27'h4000000;
  localparam logic [26:0] RESET_BLOCK  = 27'h800;

  // Restoring divider: one quotient bit per step over the whole offset.
  localparam int          OFFSET_W     = 41;
  localparam logic [5:0]  DIV_LAST     = 6'(OFFSET_W - 1);

  // Item command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    STAT_STORED     = 3'd0,
    STAT_HOLE       = 3'd1,
    STAT_BEYOND     = 3'd2,
    STAT_BAD_BYTE   = 3'd3,
    STAT_FIRST_HOLE = 3'd4,
    STAT_NOT_READY  = 3'd5
  } status_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  map_byte;
    logic [40:0] offset;
    logic [31:0] length;
  } req_word_t;

  typedef struct packed {
    status_t     status;
    logic [41:0] physical_address;
    logic [26:0] segment_length;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_RANGE,
    ST_MUL,
    ST_FINAL,
    ST_PUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_exec;
    logic res_not_ready;
    logic div_init;
    logic div_step;
    logic res_beyond;
    logic mem_read;
    logic mul;
    logic res_final;
    logic out_push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic not_ready;
    logic div_last;
    logic beyond;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sparse_block_map_translator_core.sv =====
// ============================================================================
// Sparse block map translator core
// Turns logical byte offsets of a sparse block-mapped image into file addresses.
// ============================================================================
// Usage: the host first writes the block size through cfg_write_en and
// cfg_write_data while the core is idle, then loads the map one byte per
// request word with command = load, in block order. Once every map entry is
// loaded with block zero stored, read words (offset, length) return one
// segment each: a stored run with its file address, a hole, or a position
// beyond the map. The caller reissues the request for the remaining bytes.
// Both channels use valid and stall; one response word follows every request.
// A load word passes from decode to the push step and into the output
// register. A read word runs through the restoring divider, which produces
// one quotient bit of the 41-bit offset per cycle, then the range check, the
// map memory read, the index times block size multiply and the final address
// add. A read that fails its readiness check goes from decode to the push
// step. One word is in work at a time.
// Reset clears the load position, the stored block count, the map fault flag
// and restores the default block size of 2048; the map memory is not cleared,
// since no read is answered before every entry has been written again.
// A stalled response holds in the output register; the core still takes the
// next request and parks its result until the output register frees up.
// ============================================================================
`default_nettype none

module sparse_block_map_translator_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  sbmt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output sbmt_pkg::rsp_word_t rsp,
  input  wire                 cfg_write_en,
  input  wire  [26:0]         cfg_write_data
);

  sbmt_pkg::cmd_t cmd;
  sbmt_pkg::sts_t sts;

  // The controller walks each word through its steps and only ever
  // accepts a new word from its idle state.
  sbmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the map memory, the divider and the output register.
  sbmt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sbmt_ctrl.sv =====
// ============================================================================
// Sparse block map translator controller
// Sequences one word at a time through decode, divide, lookup and result.
// ============================================================================
`default_nettype none

module sbmt_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_stall,
  output sbmt_pkg::cmd_t cmd,
  input  sbmt_pkg::sts_t sts
);

  sbmt_pkg::state_t state;
  sbmt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      sbmt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = sbmt_pkg::ST_DECODE;
        end
      end
      sbmt_pkg::ST_DECODE: begin
        if (!sts.is_read) begin
          cmd.load_exec = 1'b1;
          state_next    = sbmt_pkg::ST_PUSH;
        end else if (sts.not_ready) begin
          cmd.res_not_ready = 1'b1;
          state_next        = sbmt_pkg::ST_PUSH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = sbmt_pkg::ST_DIV;
        end
      end
      sbmt_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = sbmt_pkg::ST_RANGE;
        end
      end
      sbmt_pkg::ST_RANGE: begin
        if (sts.beyond) begin
          cmd.res_beyond = 1'b1;
          state_next     = sbmt_pkg::ST_PUSH;
        end else begin
          cmd.mem_read = 1'b1;
          state_next   = sbmt_pkg::ST_MUL;
        end
      end
      sbmt_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sbmt_pkg::ST_FINAL;
      end
      sbmt_pkg::ST_FINAL: begin
        cmd.res_final = 1'b1;
        state_next    = sbmt_pkg::ST_PUSH;
      end
      sbmt_pkg::ST_PUSH: begin
        if (sts.out_free) begin
          cmd.out_push = 1'b1;
          state_next   = sbmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbmt_datapath.sv =====
// ============================================================================
// Sparse block map translator datapath
// Map memory, load bookkeeping, offset divider, address multiply and output.
// ============================================================================
`default_nettype none

module sbmt_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  sbmt_pkg::req_word_t req,
  input  wire                 cfg_write_en,
  input  wire  [26:0]         cfg_write_data,
  input  sbmt_pkg::cmd_t      cmd,
  output sbmt_pkg::sts_t      sts,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output sbmt_pkg::rsp_word_t rsp
);

  // Map memory: bit 15 marks a stored block, bits 14..0 hold its index.
  logic [15:0] map_mem [0:sbmt_pkg::MAP_ENTRIES-1];
  logic [15:0] rd_data;

  // Captured word.
  logic        cmd_r;
  logic [7:0]  byte_r;
  logic [40:0] off_r;
  logic [31:0] len_r;

  // Load bookkeeping.
  logic [26:0] block_size;
  logic [14:0] stored_count;
  logic [15:0] load_index;
  logic        map_fault;
  logic        first_stored;

  // Divider.
  logic [40:0] quo;
  logic [26:0] rem;
  logic [5:0]  div_cnt;
  logic [27:0] trial;
  logic [27:0] trial_diff;

  // Address and segment.
  logic [41:0] prod;
  logic [26:0] seg_r;
  logic [26:0] seg_full;

  // Pending result.
  sbmt_pkg::rsp_word_t res;

  logic map_full;
  logic load_write;

  assign map_full   = load_index >= sbmt_pkg::MAP_ENTRIES;
  assign load_write = cmd.load_exec && !map_fault && !map_full && (byte_r <= 8'd1);

  assign trial      = {rem, quo[40]};
  assign trial_diff = trial - {1'b0, block_size};
  assign seg_full   = block_size - rem;

  assign sts.is_read   = (cmd_r == sbmt_pkg::CMD_READ);
  assign sts.not_ready = map_fault || !map_full || !first_stored ||
                         (block_size < sbmt_pkg::MIN_BLOCK) ||
                         (block_size > sbmt_pkg::MAX_BLOCK);
  assign sts.div_last  = (div_cnt == sbmt_pkg::DIV_LAST);
  assign sts.beyond    = quo >= {25'd0, sbmt_pkg::MAP_ENTRIES};
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (load_write) begin
      map_mem[load_index[14:0]] <= (byte_r[0]) ? {1'b1, stored_count} : 16'd0;
    end
    if (cmd.mem_read) begin
      rd_data <= map_mem[quo[14:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= sbmt_pkg::RESET_BLOCK;
      stored_count <= '0;
      load_index   <= '0;
      map_fault    <= 1'b0;
      first_stored <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        block_size <= cfg_write_data;
      end
      if (cmd.load_exec && !map_fault && !map_full && (byte_r > 8'd1)) begin
        map_fault <= 1'b1;
      end
      if (load_write) begin
        load_index <= load_index + 16'd1;
        if (byte_r[0]) begin
          stored_count <= stored_count + 15'd1;
        end
        if (load_index == 16'd0) begin
          first_stored <= byte_r[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= req.command;
      byte_r <= req.map_byte;
      off_r  <= req.offset;
      len_r  <= req.length;
    end

    if (cmd.div_init) begin
      quo     <= off_r;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, block_size}) begin
        rem <= trial_diff[26:0];
        quo <= {quo[39:0], 1'b1};
      end else begin
        rem <= trial[26:0];
        quo <= {quo[39:0], 1'b0};
      end
      div_cnt <= div_cnt + 6'd1;
    end

    if (cmd.mul) begin
      prod  <= 42'(rd_data[14:0] * block_size);
      seg_r <= ({5'd0, seg_full} > len_r) ? len_r[26:0] : seg_full;
    end

    if (cmd.load_exec) begin
      res.physical_address <= '0;
      res.segment_length   <= '0;
      if (map_fault) begin
        res.status <= sbmt_pkg::STAT_BAD_BYTE;
      end else if (map_full) begin
        res.status <= sbmt_pkg::STAT_BEYOND;
      end else if (byte_r > 8'd1) begin
        res.status <= sbmt_pkg::STAT_BAD_BYTE;
      end else if (load_index == 16'd0 && !byte_r[0]) begin
        res.status <= sbmt_pkg::STAT_FIRST_HOLE;
      end else begin
        res.status <= sbmt_pkg::STAT_STORED;
      end
    end else if (cmd.res_not_ready) begin
      res.status           <= sbmt_pkg::STAT_NOT_READY;
      res.physical_address <= '0;
      res.segment_length   <= '0;
    end else if (cmd.res_beyond) begin
      res.status           <= sbmt_pkg::STAT_BEYOND;
      res.physical_address <= '0;
      res.segment_length   <= '0;
    end else if (cmd.res_final) begin
      res.segment_length <= seg_r;
      if (rd_data[15]) begin
        res.status           <= sbmt_pkg::STAT_STORED;
        res.physical_address <= sbmt_pkg::HEADER_BYTES + prod + {15'd0, rem};
      end else begin
        res.status           <= sbmt_pkg::STAT_HOLE;
        res.physical_address <= '0;
      end
    end

    if (cmd.out_push) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sbmt_translation_checker.sv =====
// ============================================================================
// Block map translation checker
// Watches the request, response and configuration ports of the translator. It
// keeps its own copy of the block map, the load position, the fault flag and
// the block size, and predicts one answer per accepted request word. Each
// accepted response word is compared field by field with the oldest answer
// still owed.
// ============================================================================
module sbmt_translation_checker
  import sbmt_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  input  wire         req_stall,
  input  req_word_t   req,
  input  wire         rsp_valid,
  input  wire         rsp_stall,
  input  rsp_word_t   rsp,
  input  wire         cfg_write_en,
  input  wire  [26:0] cfg_write_data,
  output int          mismatches,
  output int          outstanding
);

  bit [15:0]   map_copy [0:int'(MAP_ENTRIES)-1];
  bit [15:0]   words_loaded;
  bit [14:0]   next_stored;
  bit          map_broken;
  logic [26:0] bytes_per_block;
  rsp_word_t   owed_answers [$];
  int          error_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Applies one request word to the shadow state and returns the answer.
  function automatic rsp_word_t predict_answer(input req_word_t w);
    rsp_word_t       r;
    longint unsigned bs, blk, in_blk, seg, addr;
    bit [15:0]       entry;
    r = '0;
    r.status = STAT_STORED;
    if (w.command == CMD_LOAD) begin
      if (map_broken) begin
        r.status = STAT_BAD_BYTE;
      end else if (words_loaded >= MAP_ENTRIES) begin
        r.status = STAT_BEYOND;
      end else if (w.map_byte > 8'd1) begin
        map_broken = 1'b1;
        r.status = STAT_BAD_BYTE;
      end else begin
        if (w.map_byte == 8'd1) begin
          map_copy[words_loaded] = {1'b1, next_stored};
          next_stored = next_stored + 15'd1;
        end else begin
          map_copy[words_loaded] = '0;
        end
        if (words_loaded == 16'd0 && w.map_byte == 8'd0) r.status = STAT_FIRST_HOLE;
        words_loaded = words_loaded + 16'd1;
      end
      return r;
    end
    bs = bytes_per_block;
    if (map_broken || words_loaded < MAP_ENTRIES || !map_copy[0][15] ||
        bs < MIN_BLOCK || bs > MAX_BLOCK) begin
      r.status = STAT_NOT_READY;
      return r;
    end
    blk    = w.offset / bs;
    in_blk = w.offset % bs;
    if (blk >= MAP_ENTRIES) begin
      r.status = STAT_BEYOND;
      return r;
    end
    seg = bs - in_blk;
    if (seg > w.length) seg = w.length;
    r.segment_length = seg[26:0];
    entry = map_copy[blk];
    if (!entry[15]) begin
      r.status = STAT_HOLE;
    end else begin
      addr = HEADER_BYTES + entry[14:0] * bs + in_blk;
      r.physical_address = addr[41:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      words_loaded    = '0;
      next_stored     = '0;
      map_broken      = 1'b0;
      bytes_per_block = RESET_BLOCK;
      owed_answers.delete();
    end else begin
      if (cfg_write_en) bytes_per_block = cfg_write_data;
      if (rsp_valid && !rsp_stall) begin
        if (owed_answers.size() == 0) begin
          error_count++;
          $display("%0t: unexpected response word: status %0d addr 0x%h len %0d",
                   $time, rsp.status, rsp.physical_address, rsp.segment_length);
        end else begin
          want = owed_answers.pop_front();
          if (rsp.status !== want.status ||
              rsp.physical_address !== want.physical_address ||
              rsp.segment_length !== want.segment_length) begin
            error_count++;
            $display({"%0t: response mismatch: expected status %0d addr 0x%h len %0d,",
                      " got status %0d addr 0x%h len %0d"},
                     $time, want.status, want.physical_address, want.segment_length,
                     rsp.status, rsp.physical_address, rsp.segment_length);
          end
        end
      end
      if (req_valid && !req_stall) owed_answers.push_back(predict_answer(req));
    end
    outstanding <= owed_answers.size();
    mismatches  <= error_count;
  end

endmodule

// ===== tb/tb_sparse_block_map_translator_core.sv =====
// ============================================================================
// Sparse block map translator testbench
// Loads the whole block map with random stored and hole bytes, then sends
// translation requests under a series of block sizes, while both channels
// idle and stall at random. A checker beside the core predicts every answer.
// ============================================================================
module tb_sparse_block_map_translator_core;
  import sbmt_pkg::*;

  // Highest valid block number of the map.
  localparam int MAP_LAST         = int'(MAP_ENTRIES) - 1;
  // The receiver holds off this long when asked, long enough for the core to
  // park a result and then stall its request side.
  localparam int LONG_HOLD_CYCLES = 300;
  // This covers the tail after the last word.
  localparam int TAIL_CYCLES      = 60;
  localparam int READS_PER_SIZE   = 140;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        req_valid      = 1'b0;
  logic        req_stall;
  req_word_t   req            = '0;
  logic        rsp_valid;
  logic        rsp_stall      = 1'b0;
  rsp_word_t   rsp;
  logic        cfg_write_en   = 1'b0;
  logic [26:0] cfg_write_data = '0;

  int          mismatches;
  int          outstanding;

  // Stimulus bookkeeping, used for pacing and for the closing summary.
  int unsigned     hold_requests = 0;
  int              burst_left    = 0;
  longint unsigned cur_block     = 2048;
  int              loads_sent    = 0;
  int              reads_sent    = 0;
  int              sizes_used    = 0;

  always #2 clk = ~clk;

  sparse_block_map_translator_core DUT (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  sbmt_translation_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Gap before the next request word. Most words follow at once or after a
  // short pause, a few after a long one, and now and then a burst of words
  // goes out back to back with no idling at all.
  function automatic int sender_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      burst_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 195) return $urandom_range(4, 10);
    return $urandom_range(11, 24);
  endfunction

  // A map load word. The offset and length are don't-care for loads and are
  // filled with noise so the core is seen to ignore them.
  function automatic req_word_t load_word(input logic [7:0] b);
    req_word_t w;
    w.command  = CMD_LOAD;
    w.map_byte = b;
    w.offset   = 41'({$urandom, $urandom});
    w.length   = $urandom;
    return w;
  endfunction

  function automatic req_word_t read_word(input longint unsigned off,
                                          input logic [31:0] len);
    req_word_t w;
    w.command  = CMD_READ;
    w.map_byte = 8'($urandom);
    w.offset   = off[40:0];
    w.length   = len;
    return w;
  endfunction

  // Random read for block size bs. Most land inside the map, with extra
  // weight on the first and last block, on the block edges and just past the
  // end of the map; a few offsets are fully random.
  function automatic req_word_t random_read(input longint unsigned bs);
    longint unsigned blk, in_blk, off;
    logic [31:0]     len;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      off = {$urandom, $urandom};
    end else begin
      if (pick < 16) blk = MAP_LAST + $urandom_range(1, 8);
      else if (pick < 26) blk = ($urandom_range(0, 1) == 0) ? 0 : MAP_LAST;
      else blk = $urandom_range(0, MAP_LAST);
      case ($urandom_range(0, 3))
        0: in_blk = 0;
        1: in_blk = bs - 1;
        default: in_blk = $urandom_range(0, 32'(bs - 1));
      endcase
      off = blk * bs + in_blk;
    end
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = '1;
      2, 3, 4: len = $urandom_range(1, 32'(bs));
      default: len = $urandom;
    endcase
    return read_word(off, len);
  endfunction

  // Offers one word and returns at the edge where it is taken. The payload
  // holds while the core stalls; valid is left high for the caller.
  task automatic offer(input req_word_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (w.command == CMD_READ) reads_sent++;
    else loads_sent++;
  endtask

  // Stops sending and waits until every answer owed has arrived. The first
  // edge lets the checker count a word taken at the current edge.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Block size writes happen only with the core idle, after a drain.
  task automatic set_block_size(input logic [26:0] v);
    cfg_write_data <= v;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    @(posedge clk);
    cur_block = v;
    sizes_used++;
  endtask

  // Response side. Each pass picks a stall level and holds it for a count of
  // cycles: short random stalls, calm stretches with no stall at all, and the
  // long hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int unsigned holds_done;
    int          cycles;
    logic        stall_now;
    int          r;
    holds_done = 0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_requests != holds_done) begin
        holds_done++;
        stall_now = 1'b1;
        cycles    = LONG_HOLD_CYCLES;
      end else if (r < 2) begin
        stall_now = 1'b0;
        cycles    = $urandom_range(60, 200);
      end else if (r < 60) begin
        stall_now = 1'b0;
        cycles    = $urandom_range(1, 8);
      end else if (r < 92) begin
        stall_now = 1'b1;
        cycles    = $urandom_range(1, 3);
      end else if (r < 98) begin
        stall_now = 1'b1;
        cycles    = $urandom_range(4, 10);
      end else begin
        stall_now = 1'b1;
        cycles    = $urandom_range(11, 24);
      end
      rsp_stall <= stall_now;
      repeat (cycles) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0]  b;
    logic [26:0] bad_sizes [4];
    logic [26:0] good_sizes [10];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before the map is loaded every read answers not-ready. A block size of
    // zero is out of range too, so both reasons hold at first.
    set_block_size(27'd0);
    offer(read_word(0, '0));
    offer(read_word({$urandom, $urandom}, '1));
    drain();
    set_block_size(MIN_BLOCK);
    offer(read_word(64'h1FF_FFFF_FFFF, 32'd1));

    // Load the whole map. Block zero must be stored or no read is ever
    // served; block one and the block before the last are holes so the
    // directed reads below know where to find one. Not-ready reads are mixed
    // in, and partway through the receiver holds off for a long stretch
    // while loads keep coming, so the core fills up and stalls its input.
    for (int i = 0; i <= MAP_LAST; i++) begin
      if (i == 0 || i == 2 || i == MAP_LAST) b = 8'd1;
      else if (i == 1 || i == MAP_LAST - 1) b = 8'd0;
      else b = ($urandom_range(0, 2) != 0) ? 8'd1 : 8'd0;
      if (i == 9000) hold_requests <= hold_requests + 1;
      if ($urandom_range(0, 149) == 0) offer(random_read(cur_block));
      offer(load_word(b));
    end
    drain();

    // Directed reads at the smallest block size: zero length on a stored
    // block, a full block, the last byte of a block, a hole, the last map
    // block, and offsets just past the map and at the top of the range.
    offer(read_word(0, '0));
    offer(read_word(0, '1));
    offer(read_word(2047, 32'd1));
    offer(read_word(2048 + 5, 32'd100));
    offer(read_word(64'd32759 * 64'd2048 + 64'd2047, '1));
    offer(read_word(64'd32760 * 64'd2048, 32'd9));
    offer(read_word(64'h1FF_FFFF_FFFF, 32'd5));
    // Loads once the map is full are turned away as past the end, even a
    // byte that would otherwise be invalid.
    offer(load_word(8'd1));
    offer(load_word(8'hFF));
    drain();

    // Largest block size: a segment of the full 64 MiB, the last byte of the
    // last block, and the very top offset, which lies beyond the map.
    set_block_size(MAX_BLOCK);
    offer(read_word(0, '1));
    offer(read_word(64'd32759 * 64'd67108864 + 64'd67108863, '1));
    offer(read_word(64'h1FF_FFFF_FFFF, '1));
    drain();

    // Block sizes just outside the legal range, and the register's extremes,
    // all leave reads not-ready.
    bad_sizes = '{27'd2047, 27'd67108865, 27'h7FF_FFFF, 27'd0};
    foreach (bad_sizes[k]) begin
      set_block_size(bad_sizes[k]);
      repeat (4) offer(random_read(2048));
      drain();
    end

    // Random phases, one per block size, powers of two and odd sizes among
    // them. A few loads past the end of the map are mixed in as noise.
    good_sizes = '{MIN_BLOCK, MAX_BLOCK, 27'd4096, 27'd3000, 27'd65536, 27'd2049,
                   27'd67108863, 27'd1048576,
                   27'($urandom_range(2048, 67108864)), 27'($urandom_range(2048, 70000))};
    foreach (good_sizes[k]) begin
      set_block_size(good_sizes[k]);
      for (int n = 0; n < READS_PER_SIZE; n++) begin
        if (k == 3 && n == 60) hold_requests <= hold_requests + 1;
        if ($urandom_range(0, 19) == 0) offer(load_word(8'($urandom)));
        else offer(random_read(cur_block));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d map loads and %0d translation reads over %0d block sizes,",
             loads_sent, reads_sent, sizes_used);
    $display("with stored, hole, beyond-map and not-ready answers under random stalls.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Safety net: several times the slowest legal run, every word waiting out
  // the longest gap and the longest stall.
  initial begin : watchdog
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sbmt_pkg.sv
hw/rtl/sbmt_ctrl.sv
hw/rtl/sbmt_datapath.sv
hw/rtl/sparse_block_map_translator_core.sv
tb/sbmt_translation_checker.sv
tb/tb_sparse_block_map_translator_core.sv
